// ===== hdl/lfsa_pkg.sv =====
// package: sizes, register map and controller/datapath link types for the slot allocator
`default_nettype none
package lfsa_pkg;

   localparam int SLOTS      = 64;
   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS   = $clog2(SLOTS + 1);
   localparam int TIME_BITS  = 32;
   localparam int ID_BITS    = 16;
   localparam int IN_TIME_BITS = 32;
   localparam int GRANT_BITS = 6;
   localparam int EXT_BITS   = (SLOT_BITS > GRANT_BITS) ? SLOT_BITS : GRANT_BITS;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TARGET_ID_ADDR = CSR_ADDR_BITS'(0);

   typedef struct packed {
      logic load_req;
      logic scan_step;
      logic commit;
   } lfsa_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } lfsa_status_type;

endpackage
`default_nettype wire

// ===== hdl/lfsa_if.sv =====
// interfaces: request channel and result channel
`default_nettype none
interface lfsa_req_if;
   import lfsa_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ID_BITS-1:0]      req_id;
   logic [IN_TIME_BITS-1:0] arrive_time;
   logic [IN_TIME_BITS-1:0] leave_time;
   modport source (output valid, output req_id, output arrive_time, output leave_time,
                   input ready);
   modport sink (input valid, input req_id, input arrive_time, input leave_time,
                 output ready);
endinterface

interface lfsa_rsp_if;
   import lfsa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [GRANT_BITS-1:0] granted_slot;
   logic [ID_BITS-1:0]    echo_id;
   logic                  is_target;
   logic                  no_free;
   modport source (output valid, output granted_slot, output echo_id, output is_target,
                   output no_free, input ready);
   modport sink (input valid, input granted_slot, input echo_id, input is_target,
                 input no_free, output ready);
endinterface
`default_nettype wire

// ===== hdl/lfsa_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module lfsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== hdl/lfsa_ctrl.sv =====
// controller: request load, slot sweep and result commit sequencing
`default_nettype none
module lfsa_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire lfsa_pkg::lfsa_status_type status,
   output lfsa_pkg::lfsa_cmd_type        cmd
);
   import lfsa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== hdl/lfsa_datapath.sv =====
// datapath: busy bits, leave-time memory sweep, lowest free search and result word register
`default_nettype none
module lfsa_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lfsa_pkg::lfsa_cmd_type               cmd,
   output lfsa_pkg::lfsa_status_type                 status,
   input  wire logic [lfsa_pkg::ID_BITS-1:0]         target_id,
   input  wire logic [lfsa_pkg::ID_BITS-1:0]         req_id,
   input  wire logic [lfsa_pkg::IN_TIME_BITS-1:0]    arrive_time,
   input  wire logic [lfsa_pkg::IN_TIME_BITS-1:0]    leave_time,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [lfsa_pkg::GRANT_BITS-1:0]      rsp_granted_slot,
   output logic      [lfsa_pkg::ID_BITS-1:0]         rsp_echo_id,
   output logic                                      rsp_is_target,
   output logic                                      rsp_no_free
);
   import lfsa_pkg::*;

   localparam logic [CNT_BITS-1:0] SLOTS_CNT = CNT_BITS'(SLOTS);

   logic [SLOTS-1:0]      busy_ff, busy_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic [SLOT_BITS-1:0]  eval_idx_ff, eval_idx_in;
   logic                  found_ff, found_in;
   logic [SLOT_BITS-1:0]  grant_ff, grant_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [TIME_BITS-1:0]  arrive_ff, arrive_in;
   logic [TIME_BITS-1:0]  leave_ff, leave_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [GRANT_BITS-1:0] slot_out_ff, slot_out_in;
   logic [ID_BITS-1:0]    echo_ff, echo_in;
   logic                  target_ff, target_in;
   logic                  no_free_ff, no_free_in;

   logic                  ram_we;
   logic                  ram_re;
   logic [SLOT_BITS-1:0]  ram_raddr;
   logic [TIME_BITS-1:0]  ram_rdata;
   logic                  expired;
   logic                  slot_free;
   logic [EXT_BITS-1:0]   grant_ext;

   lfsa_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (SLOTS)
   ) u_leave_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (grant_ff),
      .wr_data (leave_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign expired   = busy_ff[eval_idx_ff] && (ram_rdata <= arrive_ff);
   assign slot_free = !busy_ff[eval_idx_ff] || expired;
   assign grant_ext = EXT_BITS'(grant_ff);

   assign status.scan_done = (cnt_ff == SLOTS_CNT) && !eval_valid_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      busy_in       = busy_ff;
      cnt_in        = cnt_ff;
      eval_valid_in = eval_valid_ff;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      grant_in      = grant_ff;
      id_in         = id_ff;
      arrive_in     = arrive_ff;
      leave_in      = leave_ff;
      rsp_valid_in  = rsp_valid_ff;
      slot_out_in   = slot_out_ff;
      echo_in       = echo_ff;
      target_in     = target_ff;
      no_free_in    = no_free_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_raddr     = cnt_ff[SLOT_BITS-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_req) begin
         cnt_in        = '0;
         eval_valid_in = 1'b0;
         found_in      = 1'b0;
         id_in         = req_id;
         arrive_in     = TIME_BITS'(arrive_time);
         leave_in      = TIME_BITS'(leave_time);
      end

      if (cmd.scan_step) begin
         if (cnt_ff < SLOTS_CNT) begin
            ram_re        = 1'b1;
            cnt_in        = cnt_ff + CNT_BITS'(1);
            eval_valid_in = 1'b1;
            eval_idx_in   = cnt_ff[SLOT_BITS-1:0];
         end else begin
            eval_valid_in = 1'b0;
         end
      end

      // release expired slot, note first free one
      if (eval_valid_ff) begin
         if (expired) begin
            busy_in[eval_idx_ff] = 1'b0;
         end
         if (!found_ff && slot_free) begin
            found_in = 1'b1;
            grant_in = eval_idx_ff;
         end
      end

      if (cmd.commit) begin
         if (found_ff) begin
            busy_in[grant_ff] = 1'b1;
            ram_we            = 1'b1;
         end
         rsp_valid_in = 1'b1;
         slot_out_in  = found_ff ? grant_ext[GRANT_BITS-1:0] : '0;
         echo_in      = id_ff;
         target_in    = (id_ff == target_id);
         no_free_in   = !found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         cnt_ff        <= '0;
         eval_valid_ff <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         eval_valid_ff <= eval_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= eval_idx_in;
      grant_ff    <= grant_in;
      id_ff       <= id_in;
      arrive_ff   <= arrive_in;
      leave_ff    <= leave_in;
      slot_out_ff <= slot_out_in;
      echo_ff     <= echo_in;
      target_ff   <= target_in;
      no_free_ff  <= no_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = slot_out_ff;
   assign rsp_echo_id      = echo_ff;
   assign rsp_is_target    = target_ff;
   assign rsp_no_free      = no_free_ff;

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("commit while result word still held");

   a_load_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> (cnt_ff == '0) && !found_ff && !eval_valid_ff)
      else $error("sweep not restarted on request load");

   a_grant_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && found_ff) |=> busy_ff[$past(grant_ff)])
      else $error("granted slot not marked busy");

   a_eval_follows_read: assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff |-> (cnt_ff != '0))
      else $error("slot evaluated without a preceding read");
endmodule
`default_nettype wire

// ===== hdl/lowest_free_slot_timed_allocator_core.sv =====
// Lowest-free-slot allocator: each request word releases every busy slot whose leave time is at
// or before its arrival, then takes the lowest free slot and stores its leave time there. One
// request is handled at a time, in order from acceptance to the next ready: a load step, a sweep
// of the leave-time memory at one entry per cycle through its registered read port, and a commit
// step that writes the memory (when a slot was found) and the result register. A finished result
// waits in its register while the next request is taken; commit of that next request holds until
// the result port has drained. The target id register sits at byte address 0 of the csr port; the
// user must write it only while the block is idle, and the block itself does not enforce this.
`default_nettype none
module lowest_free_slot_timed_allocator_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   lfsa_req_if.sink                                   req_in,
   lfsa_rsp_if.source                                 rsp_out,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [lfsa_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [lfsa_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [lfsa_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                       pready
);
   import lfsa_pkg::*;

   logic [ID_BITS-1:0] target_id_ff, target_id_in;
   logic               csr_write;
   logic               req_ready;
   lfsa_cmd_type       cmd;
   lfsa_status_type    status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      target_id_in = target_id_ff;
      if (csr_write && (paddr == CSR_TARGET_ID_ADDR)) begin
         target_id_in = pwdata[ID_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff <= '0;
      end else begin
         target_id_ff <= target_id_in;
      end
   end

   assign prdata = (paddr == CSR_TARGET_ID_ADDR) ? CSR_DATA_BITS'(target_id_ff) : '0;

   assign req_in.ready = req_ready;

   lfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_in.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfsa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .target_id        (target_id_ff),
      .req_id           (req_in.req_id),
      .arrive_time      (req_in.arrive_time),
      .leave_time       (req_in.leave_time),
      .rsp_valid        (rsp_out.valid),
      .rsp_ready        (rsp_out.ready),
      .rsp_granted_slot (rsp_out.granted_slot),
      .rsp_echo_id      (rsp_out.echo_id),
      .rsp_is_target    (rsp_out.is_target),
      .rsp_no_free      (rsp_out.no_free)
   );
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for the lowest-free-slot timed allocator: directed and random requests checked per word
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import lfsa_pkg::*;

   typedef struct packed {
      logic [GRANT_BITS-1:0] slot;
      logic [ID_BITS-1:0]    id;
      logic                  hit;
      logic                  full;
   } grant_word_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;

   lfsa_req_if req_bus ();
   lfsa_rsp_if rsp_bus ();

   lowest_free_slot_timed_allocator_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the slot table and the target register
   logic [SLOTS-1:0]        slot_busy;
   logic [IN_TIME_BITS-1:0] slot_leave [SLOTS];
   logic [ID_BITS-1:0]      target_cfg;

   grant_word_type grant_fifo [$];

   logic [IN_TIME_BITS-1:0] arrive_now;
   int burst_left;
   int hold_asks;
   int hold_len;
   int mismatches;
   int sent_words;
   int checked_words;
   int full_words;
   int hit_words;
   int target_writes;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(50_000_000);
      $display("FAILED: results differ");
      $finish;
   end

   function automatic grant_word_type predict_grant(input logic [ID_BITS-1:0] id,
                                                    input logic [IN_TIME_BITS-1:0] arrive,
                                                    input logic [IN_TIME_BITS-1:0] leave);
      grant_word_type w;
      int found;
      found = -1;
      for (int s = 0; s < SLOTS; s++) begin
         if (slot_busy[s] && slot_leave[s] <= arrive) slot_busy[s] = 1'b0;
      end
      for (int s = 0; s < SLOTS && found < 0; s++) begin
         if (!slot_busy[s]) found = s;
      end
      if (found >= 0) begin
         slot_busy[found] = 1'b1;
         slot_leave[found] = leave;
      end
      w.slot = (found >= 0) ? GRANT_BITS'(found) : '0;
      w.id   = id;
      w.hit  = (id == target_cfg);
      w.full = (found < 0);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input longint expected,
                                  input longint actual);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %0d at %0t: %s expected %0h got %0h",
                  mismatches, $realtime, what, expected, actual);
   endtask

   // result word checker
   always @(posedge clock) begin : check_results
      grant_word_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (grant_fifo.size() == 0) begin
            report_mismatch("unexpected word, echo_id", 0, rsp_bus.echo_id);
         end else begin
            exp = grant_fifo.pop_front();
            checked_words++;
            if (exp.full) full_words++;
            if (exp.hit) hit_words++;
            if (rsp_bus.granted_slot !== exp.slot)
               report_mismatch("granted_slot", exp.slot, rsp_bus.granted_slot);
            if (rsp_bus.echo_id !== exp.id)
               report_mismatch("echo_id", exp.id, rsp_bus.echo_id);
            if (rsp_bus.is_target !== exp.hit)
               report_mismatch("is_target", exp.hit, rsp_bus.is_target);
            if (rsp_bus.no_free !== exp.full)
               report_mismatch("no_free", exp.full, rsp_bus.no_free);
         end
      end
   end

   // receiver: stall pattern of its own plus an occasional long hold
   initial begin : receiver
      int mode;
      int mode_left;
      int stall_left;
      int hold_left;
      int hold_seen;
      mode = 0;
      mode_left = 0;
      stall_left = 0;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            case (mode)
               0: rsp_bus.ready = 1'b1;
               1: rsp_bus.ready = 1'($urandom_range(0, 1));
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_bus.ready = 1'b0;
                  end else begin
                     rsp_bus.ready = 1'b1;
                     if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 120);
                  end
               end
            endcase
         end
      end
   end

   task automatic send_request(input logic [ID_BITS-1:0] id,
                               input logic [IN_TIME_BITS-1:0] arrive,
                               input logic [IN_TIME_BITS-1:0] leave);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
         if (gap > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid       = 1'b1;
      req_bus.req_id      = id;
      req_bus.arrive_time = arrive;
      req_bus.leave_time  = leave;
      do @(posedge clock); while (!req_bus.ready);
      grant_fifo.push_back(predict_grant(id, arrive, leave));
      sent_words++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (grant_fifo.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
   endtask

   // write the target id, then read it back
   task automatic set_target(input logic [ID_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] readback;
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_TARGET_ID_ADDR;
      pwdata  = CSR_DATA_BITS'(value);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      target_cfg = value;
      target_writes++;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (readback[ID_BITS-1:0] !== value) report_mismatch("target_id readback", value, readback);
   endtask

   task automatic test_reset_state();
      send_request(16'h0000, 32'h0000_0000, 32'h0000_0000);
      send_request(16'h0001, 32'h0000_0000, 32'h0000_0005);
      send_request(16'h0002, 32'h0000_0004, 32'h0000_0008);
      send_request(16'h0003, 32'h0000_0005, 32'h0000_0006);
      wait_idle();
   endtask

   task automatic test_field_extremes();
      set_target(16'hFFFF);
      send_request(16'hFFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000);
      // arrival going backward
      send_request(16'h5555, 32'h0000_0000, 32'hAAAA_AAAA);
      send_request(16'hAAAA, 32'h5555_5555, 32'h0000_0010);
      // leave time before arrival
      send_request(16'h1234, 32'h0000_1000, 32'h0000_0010);
      send_request(16'h4321, 32'h0000_1000, 32'h0000_2000);
      send_request(16'h8000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();
   endtask

   task automatic test_full_table();
      logic [IN_TIME_BITS-1:0] leave;
      set_target(16'h0028);
      send_request(16'hFFFE, 32'hFFFF_FFFF, 32'h0000_0000);
      arrive_now = 32'h0100_0000;
      for (int i = 0; i < SLOTS; i++) begin
         leave = arrive_now + ((i == 5) ? 10 : (i == 40) ? 20 : 1000);
         send_request(ID_BITS'(i), arrive_now, leave);
      end
      send_request(16'h0100, arrive_now, arrive_now + 50);
      send_request(16'h0101, arrive_now + 15, arrive_now + 5000);
      send_request(16'h0102, arrive_now + 15, arrive_now + 5000);
      send_request(16'h0028, arrive_now + 20, arrive_now + 5000);
      send_request(16'h0103, arrive_now + 21, arrive_now + 5000);
      send_request(16'h0104, arrive_now + 1000, arrive_now + 1001);
      wait_idle();
   endtask

   task automatic test_result_backpressure();
      hold_len = 600;
      hold_asks++;
      burst_left = 12;
      for (int i = 0; i < 12; i++) begin
         arrive_now = arrive_now + $urandom_range(0, 30);
         send_request(ID_BITS'($urandom_range(0, 65535)), arrive_now,
                      arrive_now + $urandom_range(0, 300));
      end
      wait_idle();
   endtask

   task automatic test_random_traffic(input int count, input int max_step, input int max_dur,
                                      input logic [ID_BITS-1:0] target);
      logic [ID_BITS-1:0] id;
      int pick;
      set_target(target);
      arrive_now = $urandom();
      for (int i = 0; i < count; i++) begin
         id = ($urandom_range(0, 3) == 0) ? target_cfg : ID_BITS'($urandom_range(0, 65535));
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_request(id, $urandom(), $urandom());
         end else if (pick == 1) begin
            arrive_now = arrive_now + $urandom_range(0, max_step);
            send_request(id, arrive_now, arrive_now - $urandom_range(1, 500));
         end else begin
            arrive_now = arrive_now + $urandom_range(0, max_step);
            send_request(id, arrive_now, arrive_now + $urandom_range(0, max_dur));
         end
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.req_id = '0;
      req_bus.arrive_time = '0;
      req_bus.leave_time = '0;
      slot_busy = '0;
      for (int s = 0; s < SLOTS; s++) slot_leave[s] = '0;
      target_cfg = '0;
      arrive_now = '0;
      burst_left = 0;
      hold_asks = 0;
      hold_len = 0;
      mismatches = 0;
      sent_words = 0;
      checked_words = 0;
      full_words = 0;
      hit_words = 0;
      target_writes = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_field_extremes();
      test_full_table();
      test_result_backpressure();
      test_random_traffic(300, 4, 200, ID_BITS'($urandom_range(0, 65535)));
      test_random_traffic(300, 20, 400, 16'hFFFF);
      test_random_traffic(300, 50, 100, ID_BITS'($urandom_range(0, 65535)));
      test_random_traffic(300, 2, 600, 16'h0000);
      test_random_traffic(250, 100, 3000, ID_BITS'($urandom_range(0, 65535)));
      test_random_traffic(100, 1, 5000, 16'h8001);

      $display("run covered %0d requests and %0d checked words over %0d target settings",
               sent_words, checked_words, target_writes);
      $display("of these %0d found the table full and %0d matched the target",
               full_words, hit_words);
      if (mismatches == 0 && grant_fifo.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire
